// ===== design/dns_pkg.sv =====
package dns_pkg;

    localparam int DATA_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = 40;
    localparam int FRAC_BITS = 12;
    localparam int PRE_W     = 20;
    localparam int IDX_W     = 10;
    localparam int CFG_W     = 11;
    localparam int SIG_W     = 16;

    // Piecewise-linear sigmoid table over [-8, 8).
    localparam int SIG_ENTRIES  = 256;
    localparam int SIG_SEG_BITS = $clog2(SIG_ENTRIES);
    localparam int SIG_IDX_W    = SIG_SEG_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [CFG_W-1:0] LAYER_RESET = CFG_W'(1);

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [DATA_W-1:0] bias;
        logic                     last;
    } t_work;

    typedef logic [SIG_W-1:0] t_sig_table [SIG_ENTRIES+1];

    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Restoring long division; it only runs while the table below is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Each node holds the logistic function, rounded to Q0.16 and capped.
    function automatic t_sig_table build_sig_table();
        t_sig_table  tbl;
        logic [63:0] ad;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] s3;
        logic [63:0] s4;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] y;
        int          d;
        for (int k = 0; k <= SIG_ENTRIES; k++) begin
            d  = 2 * k - SIG_ENTRIES;
            ad = 64'((d < 0) ? -d : d);
            t  = ((ad * 64'd8) << 31) / SIG_ENTRIES;
            s  = t >> 8;
            s2 = q31_mul(s, s);
            s3 = q31_mul(s2, s);
            s4 = q31_mul(s3, s);
            e  = Q31_ONE - s + s2 / 2 - udiv64(s3, 64'd6) + udiv64(s4, 64'd24);
            for (int i = 0; i < 8; i++) begin
                e = q31_mul(e, e);
            end
            den = Q31_ONE + e;
            if (d >= 0) begin
                y = udiv64((64'd1 << 47) + den / 2, den);
            end else begin
                y = udiv64((e << 16) + den / 2, den);
            end
            tbl[k] = (y > 64'd65535) ? {SIG_W{1'b1}} : y[SIG_W-1:0];
        end
        return tbl;
    endfunction

    localparam t_sig_table SIG_TABLE = build_sig_table();

endpackage

// ===== design/dns_ifs.sv =====
interface dns_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dns_pkg::DATA_W-1:0]    weight;
    logic signed [dns_pkg::DATA_W-1:0]    activation;
    logic signed [dns_pkg::DATA_W-1:0]    bias;
    logic                                 last;

    modport source (output valid, output weight, output activation, output bias,
                    output last, input ready);
    modport sink   (input valid, input weight, input activation, input bias,
                    input last, output ready);
endinterface

interface dns_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dns_pkg::PRE_W-1:0]     preact;
    logic        [dns_pkg::SIG_W-1:0]     sigmoid_out;
    logic        [dns_pkg::IDX_W-1:0]     neuron_index;
    logic                                 saturated;

    modport source (output valid, output preact, output sigmoid_out,
                    output neuron_index, output saturated, input ready);
    modport sink   (input valid, input preact, input sigmoid_out,
                    input neuron_index, input saturated, output ready);
endinterface

// ===== design/dns_front.sv =====
module dns_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dns_in_if.sink          i_in,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output dns_pkg::t_work  o_push_data
);

    logic                                 r_valid;
    dns_pkg::t_work                       r_work;
    logic signed [dns_pkg::PROD_W-1:0]    w_prod;
    logic                                 w_accept;

    assign i_in.ready = !r_valid || i_push_ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_prod     = dns_pkg::PROD_W'(i_in.weight) * dns_pkg::PROD_W'(i_in.activation);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work.prod <= w_prod;
            r_work.bias <= i_in.bias;
            r_work.last <= i_in.last;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_work;

endmodule

// ===== design/dns_queue.sv =====
module dns_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  dns_pkg::t_work  i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output dns_pkg::t_work  o_pop_data
);

    dns_pkg::t_work                      r_mem [dns_pkg::QUEUE_DEPTH];
    logic [dns_pkg::QUEUE_PTR_W-1:0]     r_wr_ptr;
    logic [dns_pkg::QUEUE_PTR_W-1:0]     r_rd_ptr;
    logic [dns_pkg::QUEUE_CNT_W-1:0]     r_count;
    logic                                w_push;
    logic                                w_pop;

    assign o_push_ready = (r_count != dns_pkg::QUEUE_CNT_W'(dns_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dns_pkg::QUEUE_CNT_W'(dns_pkg::QUEUE_DEPTH))
        else $error("queue occupancy above depth");
`endif

endmodule

// ===== design/dns_back.sv =====
module dns_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dns_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_q_valid,
    input  dns_pkg::t_work               i_q_data,
    output logic                         o_q_pop,
    dns_out_if.source                    o_out
);

    localparam int PRE_W   = dns_pkg::PRE_W;
    localparam int ACC_W   = dns_pkg::ACC_W;
    localparam int TOT_W   = ACC_W + 2;
    localparam int IDX_W   = dns_pkg::IDX_W;
    localparam int SIG_W   = dns_pkg::SIG_W;
    localparam int DIFF_W  = SIG_W + 1;
    localparam int MUL_W   = 2 * DIFF_W;
    localparam int RND_W   = MUL_W + 1;
    localparam int SEG_B   = dns_pkg::SIG_SEG_BITS;
    localparam int SIDX_W  = dns_pkg::SIG_IDX_W;

    localparam logic signed [TOT_W-1:0] PRE_MAX = TOT_W'((64'sd1 <<< (PRE_W - 1)) - 1);
    localparam logic signed [TOT_W-1:0] PRE_MIN = -PRE_MAX - TOT_W'(1);
    localparam logic signed [PRE_W-1:0] X_MAX   = PRE_W'(32767);
    localparam logic signed [PRE_W-1:0] X_MIN   = -X_MAX - PRE_W'(1);

    logic                         w_en;
    logic                         w_pop;

    // Configuration and accumulation state
    logic [dns_pkg::CFG_W-1:0]    r_layer;
    logic [ACC_W-1:0]             r_acc;
    logic [IDX_W-1:0]             r_cnt;
    logic [ACC_W-1:0]             w_acc_sum;
    logic [IDX_W:0]               w_cnt_inc;
    logic                         w_cnt_wrap;

    // Stage 1: finished dot product
    logic                         r1_valid;
    logic [ACC_W-1:0]             r1_sum;
    logic signed [dns_pkg::DATA_W-1:0] r1_bias;
    logic [IDX_W-1:0]             r1_idx;

    // Stage 2: rounded and saturated pre-activation
    logic                         r2_valid;
    logic signed [PRE_W-1:0]      r2_pre;
    logic                         r2_sat;
    logic [IDX_W-1:0]             r2_idx;
    logic signed [TOT_W-1:0]      w_total;
    logic signed [TOT_W-1:0]      w_shift;

    // Stage 3: table lookup and slope product
    logic                         r3_valid;
    logic signed [PRE_W-1:0]      r3_pre;
    logic                         r3_sat;
    logic [IDX_W-1:0]             r3_idx;
    logic [SIG_W-1:0]             r3_y0;
    logic signed [MUL_W-1:0]      r3_prod;
    logic signed [PRE_W-1:0]      w_x;
    logic [SIG_W-1:0]             w_pos;
    logic [SIDX_W-1:0]            w_idx0;
    logic [SIDX_W-1:0]            w_idx1;
    logic [SIG_W-1:0]             w_frac;
    logic [SIG_W-1:0]             w_y0;
    logic [SIG_W-1:0]             w_y1;
    logic signed [DIFF_W-1:0]     w_diff;

    // Stage 4: output register
    logic                         r4_valid;
    logic signed [PRE_W-1:0]      r4_pre;
    logic                         r4_sat;
    logic [IDX_W-1:0]             r4_idx;
    logic [SIG_W-1:0]             r4_sig;
    logic signed [MUL_W-1:0]      w_v;
    logic [RND_W-1:0]             w_round;
    logic [RND_W-SIG_W-1:0]       w_r;
    logic [SIG_W-1:0]             w_sig;

    // The whole back pipeline advances together and holds while the result waits.
    assign w_en    = !r4_valid || o_out.ready;
    assign w_pop   = w_en && i_q_valid;
    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= dns_pkg::LAYER_RESET;
        end else if (i_cfg_wr_en) begin
            r_layer <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_acc_sum  = r_acc + ACC_W'(i_q_data.prod);
        w_cnt_inc  = {1'b0, r_cnt} + (IDX_W + 1)'(1);
        w_cnt_wrap = (w_cnt_inc >= r_layer) || w_cnt_inc[IDX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_pop && i_q_data.last;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            if (w_pop) begin
                if (i_q_data.last) begin
                    r_acc <= '0;
                    r_cnt <= w_cnt_wrap ? '0 : w_cnt_inc[IDX_W-1:0];
                end else begin
                    r_acc <= w_acc_sum;
                end
            end
        end
    end

    always_comb begin
        w_total = TOT_W'($signed(r1_sum)) + (TOT_W'(r1_bias) <<< dns_pkg::FRAC_BITS)
                + (TOT_W'(1) <<< (dns_pkg::FRAC_BITS - 1));
        w_shift = w_total >>> dns_pkg::FRAC_BITS;
    end

    always_comb begin
        if (r2_pre > X_MAX) begin
            w_x = X_MAX;
        end else if (r2_pre < X_MIN) begin
            w_x = X_MIN;
        end else begin
            w_x = r2_pre;
        end
        // Offset into [0, 65535] by flipping the sign bit of the 16-bit value.
        w_pos  = {~w_x[SIG_W-1], w_x[SIG_W-2:0]};
        w_idx0 = {1'b0, w_pos[SIG_W-1 -: SEG_B]};
        w_idx1 = w_idx0 + SIDX_W'(1);
        w_frac = SIG_W'(w_pos[SIG_W-SEG_B-1:0]) << SEG_B;
        w_y0   = dns_pkg::SIG_TABLE[w_idx0];
        w_y1   = dns_pkg::SIG_TABLE[w_idx1];
        w_diff = $signed({1'b0, w_y1}) - $signed({1'b0, w_y0});
    end

    always_comb begin
        w_v     = $signed({1'b0, r3_y0, {SIG_W{1'b0}}}) + r3_prod;
        w_round = w_v[MUL_W-1] ? RND_W'(1) << (SIG_W - 1)
                               : RND_W'($unsigned(w_v)) + (RND_W'(1) << (SIG_W - 1));
        w_r     = w_round[RND_W-1:SIG_W];
        w_sig   = (w_r > (RND_W - SIG_W)'({SIG_W{1'b1}})) ? {SIG_W{1'b1}} : w_r[SIG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_pop) begin
                r1_sum  <= w_acc_sum;
                r1_bias <= i_q_data.bias;
                r1_idx  <= r_cnt;
            end
            if (w_shift > PRE_MAX) begin
                r2_pre <= PRE_MAX[PRE_W-1:0];
                r2_sat <= 1'b1;
            end else if (w_shift < PRE_MIN) begin
                r2_pre <= PRE_MIN[PRE_W-1:0];
                r2_sat <= 1'b1;
            end else begin
                r2_pre <= w_shift[PRE_W-1:0];
                r2_sat <= 1'b0;
            end
            r2_idx  <= r1_idx;
            r3_pre  <= r2_pre;
            r3_sat  <= r2_sat;
            r3_idx  <= r2_idx;
            r3_y0   <= w_y0;
            r3_prod <= MUL_W'(w_diff) * MUL_W'($signed({1'b0, w_frac}));
            r4_pre  <= r3_pre;
            r4_sat  <= r3_sat;
            r4_idx  <= r3_idx;
            r4_sig  <= w_sig;
        end
    end

    assign o_out.valid        = r4_valid;
    assign o_out.preact       = r4_pre;
    assign o_out.sigmoid_out  = r4_sig;
    assign o_out.neuron_index = r4_idx;
    assign o_out.saturated    = r4_sat;

`ifndef SYNTHESIS
    a_last_ends_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_q_data.last) |=> (r1_valid && (r_acc == '0)))
        else $error("last transaction did not close the dot product");
    a_plain_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_q_data.last) |=> !r1_valid)
        else $error("result raised by a non-last transaction");
    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_sat) |-> ((r4_pre == PRE_MAX[PRE_W-1:0])
                                  || (r4_pre == PRE_MIN[PRE_W-1:0])))
        else $error("saturated flag set off the rails");
`endif

endmodule

// ===== design/dense_neuron_sigmoid_core.sv =====
// Channel   Dir  Modport        Payload
// i_in      in   dns_in_if      weight, activation, bias (Q4.12), last
// o_out     out  dns_out_if     preact (Q8.12), sigmoid_out (Q0.16), neuron_index, saturated
// i_cfg_*   in   write only     neurons_in_layer (11 bits)
//
// One transaction is accepted per cycle while the queue has room; the rate is set by the
// single multiplier in the front and the single 40-bit accumulator add in the back.
// A result is valid once the transaction marked last has passed the front register,
// one queue slot and four back stages (sum, round, lookup, interpolate); it leaves
// on the first edge at which the output is ready.
// Reset is synchronous and active low; it clears the accumulator, the neuron counter,
// all valid bits and sets the layer size to one.
// A stalled output holds the whole back pipeline; the four-entry queue and the front
// register keep accepting until they fill, so each side stalls on its own.
module dense_neuron_sigmoid_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [dns_pkg::CFG_W-1:0]    i_cfg_wr_data,
    dns_in_if.sink                       i_in,
    dns_out_if.source                    o_out
);

    // Front to queue: registered products tagged with bias and last.
    logic            w_push_valid;
    logic            w_push_ready;
    dns_pkg::t_work  w_push_data;

    // Queue to back.
    logic            w_pop_valid;
    logic            w_pop;
    dns_pkg::t_work  w_pop_data;

    // The front multiplies weight by activation and registers the product.
    dns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // The queue decouples the input stream from output backpressure.
    dns_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_data   (w_pop_data)
    );

    // The back accumulates, then rounds, saturates and evaluates the sigmoid.
    dns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (w_pop_valid),
        .i_q_data      (w_pop_data),
        .o_q_pop       (w_pop),
        .o_out         (o_out)
    );

endmodule

// ===== tb/dense_neuron_sigmoid_core_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the dense neuron core. A driver pushes weight and activation
// transactions from a queue, a monitor collects results, and a predictor in this
// module computes every expected result from the accepted transactions.
module dense_neuron_sigmoid_core_test;

    localparam int DW          = dns_pkg::DATA_W;
    localparam int ACC_W       = dns_pkg::ACC_W;
    localparam int PRE_W       = dns_pkg::PRE_W;
    localparam int IDX_W       = dns_pkg::IDX_W;
    localparam int CFG_W       = dns_pkg::CFG_W;
    localparam int SIG_W       = dns_pkg::SIG_W;
    localparam int FRAC        = dns_pkg::FRAC_BITS;
    localparam int NODES       = dns_pkg::SIG_ENTRIES;
    localparam int INDEX_SPAN  = 1 << IDX_W;
    localparam int PRE_MAX     = (1 << (PRE_W - 1)) - 1;
    localparam int PRE_MIN     = -PRE_MAX - 1;
    localparam int X_MAX       = (1 << (DW - 1)) - 1;
    localparam int X_MIN       = -X_MAX - 1;
    localparam int GAP_MAX     = 18;
    // Idle cycles after a drain, long enough for the front, queue and back pipeline to empty.
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 400000;

    localparam bit [63:0] Q31_UNIT = 64'd1 << 31;

    // How often a side of the bench inserts idle cycles between transactions.
    typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_ALWAYS} t_idle_mode;

    typedef struct {
        logic signed [DW-1:0] weight;
        logic signed [DW-1:0] activation;
        logic signed [DW-1:0] bias;
        logic                 last;
    } t_term;

    typedef struct {
        logic signed [PRE_W-1:0] preact;
        logic        [SIG_W-1:0] sigmoid_out;
        logic        [IDX_W-1:0] neuron_index;
        logic                    saturated;
    } t_neuron_out;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;

    dns_in_if  term_bus ();
    dns_out_if result_bus ();

    dense_neuron_sigmoid_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (term_bus),
        .o_out         (result_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the running dot product, the neuron counter and the layer size.
    logic [ACC_W-1:0] dot_acc = '0;
    int               neuron_count = 0;
    int               layer_size = 1;
    bit [SIG_W-1:0]   sig_node [0:NODES];

    t_term       pending_terms [$];
    t_neuron_out pending_results [$];

    t_term      on_wire;
    int         send_hold = 0;
    int         recv_hold = 0;
    int         recv_next = 0;
    t_idle_mode send_mode = IDLE_SOME;
    t_idle_mode recv_mode = IDLE_SOME;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    function automatic bit [63:0] mul_q31(input bit [63:0] a, input bit [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // Sigmoid nodes, evenly spaced over [-8, 8]. exp(-|x|) is found as a fourth-order
    // series at |x|/256 and then squared eight times.
    initial begin : sigmoid_nodes
        bit [63:0] mag;
        bit [63:0] s1;
        bit [63:0] s2;
        bit [63:0] s3;
        bit [63:0] s4;
        bit [63:0] e;
        bit [63:0] den;
        bit [63:0] y;
        int        node_off;
        for (int k = 0; k <= NODES; k++) begin
            node_off = 2 * k - NODES;
            mag  = 64'((node_off < 0) ? -node_off : node_off);
            s1   = (((mag * 64'd8) << 31) / NODES) >> 8;
            s2   = mul_q31(s1, s1);
            s3   = mul_q31(s2, s1);
            s4   = mul_q31(s3, s1);
            e    = Q31_UNIT - s1 + s2 / 2 - s3 / 6 + s4 / 24;
            repeat (8) e = mul_q31(e, e);
            den  = Q31_UNIT + e;
            if (node_off >= 0) begin
                y = ((64'd1 << 47) + den / 2) / den;
            end else begin
                y = ((e << 16) + den / 2) / den;
            end
            sig_node[k] = (y > 64'd65535) ? {SIG_W{1'b1}} : y[SIG_W-1:0];
        end
    end

    // Folds one accepted transaction into the dot product. On the transaction marked
    // last it rounds, saturates, looks up the sigmoid and queues the expected result.
    function automatic void absorb_term(input t_term t);
        logic [ACC_W-1:0] sum;
        longint           total;
        longint           pre;
        longint           x;
        longint           pos;
        longint           seg;
        longint           frac;
        longint           y0;
        longint           y1;
        longint           v;
        longint           r;
        t_neuron_out      res;
        sum = dot_acc + ACC_W'(longint'($signed(t.weight)) * longint'($signed(t.activation)));
        if (!t.last) begin
            dot_acc = sum;
            return;
        end
        // The wide sum is taken as signed after wrapping; the bias is aligned to Q.24.
        total = longint'($signed(sum)) + (longint'($signed(t.bias)) <<< FRAC);
        pre   = (total + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        res.saturated = 1'b0;
        if (pre > PRE_MAX) begin
            pre = PRE_MAX;
            res.saturated = 1'b1;
        end
        if (pre < PRE_MIN) begin
            pre = PRE_MIN;
            res.saturated = 1'b1;
        end
        res.preact = PRE_W'(pre);
        // Beyond [-8, 8) the input sticks to the ends of the table.
        x = (pre > X_MAX) ? X_MAX : ((pre < X_MIN) ? X_MIN : pre);
        pos  = (x - X_MIN) * NODES;
        seg  = pos >> 16;
        frac = pos & 64'hFFFF;
        if (seg >= NODES) begin
            seg  = NODES - 1;
            frac = 64'hFFFF;
        end
        y0 = sig_node[seg];
        y1 = sig_node[seg + 1];
        v  = y0 * 65536 + (y1 - y0) * frac;
        if (v < 0) begin
            v = 0;
        end
        r = (v + 32768) >> 16;
        res.sigmoid_out  = (r > 65535) ? {SIG_W{1'b1}} : SIG_W'(r);
        res.neuron_index = IDX_W'(neuron_count);
        // A layer size of zero, or one below the counter, wraps at the next result.
        neuron_count = neuron_count + 1;
        if (neuron_count >= layer_size || neuron_count >= INDEX_SPAN) begin
            neuron_count = 0;
        end
        dot_acc = '0;
        pending_results.push_back(res);
    endfunction

    function automatic int draw_gap(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : 0;
            default:   return $urandom_range(0, GAP_MAX);
        endcase
    endfunction

    // Operand draw. The scale keeps one neuron's sum small, medium or full range, so
    // that the pre-activations land all over the sigmoid and in saturation.
    function automatic logic signed [DW-1:0] pick_q412(input int scale);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        case (scale)
            0:       return DW'($urandom);
            1:       return DW'($urandom_range(0, 16383) - 8192);
            default: return DW'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    function automatic void push_term(input int w, input int a, input int b, input bit last);
        t_term t;
        t.weight     = DW'(w);
        t.activation = DW'(a);
        t.bias       = DW'(b);
        t.last       = last;
        pending_terms.push_back(t);
    endfunction

    // Random neurons: mostly short dot products, now and then a long one. The final
    // neuron of a batch may be left open, so its partial sum carries into the next.
    task automatic queue_neurons(input int n_items);
        int    left_in_neuron;
        int    scale;
        t_term t;
        left_in_neuron = 0;
        scale = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left_in_neuron == 0) begin
                left_in_neuron = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                             : $urandom_range(1, 6);
                scale = $urandom_range(0, 2);
            end
            t.weight     = pick_q412(scale);
            t.activation = pick_q412(scale);
            t.bias       = DW'($urandom);
            left_in_neuron--;
            t.last       = (left_in_neuron == 0);
            pending_terms.push_back(t);
        end
    endtask

    // Waits until every transaction is sent and every result is back, then lets the
    // pipeline settle, since trailing non-last transactions produce no result.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_terms.size() != 0 || term_bus.valid || pending_results.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_layer_size(input int value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(value);
        layer_size = value & ((1 << CFG_W) - 1);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int layer, input int n_items, input t_idle_mode sm,
                             input t_idle_mode rm);
        drain();
        send_mode = sm;
        recv_mode = rm;
        write_layer_size(layer);
        queue_neurons(n_items);
    endtask

    // Driver: a transaction stays on the bus until accepted, then the drawn gap runs
    // before the next one goes out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            term_bus.valid      <= 1'b0;
            term_bus.weight     <= '0;
            term_bus.activation <= '0;
            term_bus.bias       <= '0;
            term_bus.last       <= 1'b0;
            send_hold           <= 0;
        end else begin
            if (term_bus.valid && term_bus.ready) begin
                absorb_term(on_wire);
            end
            if (!term_bus.valid || term_bus.ready) begin
                if (send_hold != 0) begin
                    send_hold      <= send_hold - 1;
                    term_bus.valid <= 1'b0;
                end else if (pending_terms.size() != 0) begin
                    on_wire = pending_terms.pop_front();
                    term_bus.weight     <= on_wire.weight;
                    term_bus.activation <= on_wire.activation;
                    term_bus.bias       <= on_wire.bias;
                    term_bus.last       <= on_wire.last;
                    term_bus.valid      <= 1'b1;
                    send_hold           <= draw_gap(send_mode);
                end else begin
                    term_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation, and
    // ready then drops for the drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            recv_hold        <= 0;
        end else begin
            recv_next = recv_hold;
            if (result_bus.valid && result_bus.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: preact %0d", result_bus.preact);
                    mismatch_count++;
                end else begin
                    automatic t_neuron_out want = pending_results.pop_front();
                    if (result_bus.preact !== want.preact) begin
                        $error("preact: expected %0d, got %0d", want.preact,
                               result_bus.preact);
                        mismatch_count++;
                    end
                    if (result_bus.sigmoid_out !== want.sigmoid_out) begin
                        $error("sigmoid_out: expected %0d, got %0d", want.sigmoid_out,
                               result_bus.sigmoid_out);
                        mismatch_count++;
                    end
                    if (result_bus.neuron_index !== want.neuron_index) begin
                        $error("neuron_index: expected %0d, got %0d", want.neuron_index,
                               result_bus.neuron_index);
                        mismatch_count++;
                    end
                    if (result_bus.saturated !== want.saturated) begin
                        $error("saturated: expected %0d, got %0d", want.saturated,
                               result_bus.saturated);
                        mismatch_count++;
                    end
                end
                recv_next = draw_gap(recv_mode);
            end else if (recv_next != 0) begin
                recv_next = recv_next - 1;
            end
            result_bus.ready <= (recv_next == 0);
            recv_hold        <= recv_next;
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dense_neuron_sigmoid_core: mismatch");
            $finish;
        end
    end

    initial begin
        term_bus.valid      = 1'b0;
        term_bus.weight     = '0;
        term_bus.activation = '0;
        term_bus.bias       = '0;
        term_bus.last       = 1'b0;
        result_bus.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, at the reset layer size of one.
        // Empty sum, then the bias alone at both ends of the table.
        push_term(0, 0, 0, 1'b1);
        push_term(0, 0, 32767, 1'b1);
        push_term(0, 0, -32768, 1'b1);
        // Largest products pile past the top and bottom of Q8.12; one alone stays in range.
        push_term(32767, 32767, 5, 1'b0);
        push_term(32767, 32767, -1, 1'b0);
        push_term(32767, 32767, 32767, 1'b1);
        push_term(-32768, 32767, 0, 1'b0);
        push_term(-32768, 32767, 0, 1'b0);
        push_term(-32768, 32767, -32768, 1'b1);
        push_term(-32768, -32768, 0, 1'b1);
        // Rounding at and around one half.
        push_term(1, 2048, 0, 1'b1);
        push_term(-1, 2048, 0, 1'b1);
        push_term(1, 2047, 0, 1'b1);
        push_term(-1, 2049, 0, 1'b1);
        // A bias on a transaction that is not last has no effect.
        push_term(4096, 4096, 32767, 1'b0);
        push_term(0, 0, 0, 1'b1);
        // Rounding that lands one past the top saturates; one less stays in range.
        push_term(32767, 32767, 0, 1'b0);
        push_term(32767, 32767, 0, 1'b0);
        push_term(1, 2046, 31, 1'b1);
        push_term(32767, 32767, 0, 1'b0);
        push_term(32767, 32767, 0, 1'b0);
        push_term(1, 2045, 31, 1'b1);

        // Random part over several layer sizes and idling patterns.
        run_phase(3, 110, IDLE_ALWAYS, IDLE_NONE);
        run_phase(1024, 110, IDLE_NONE, IDLE_ALWAYS);
        run_phase(0, 80, IDLE_NONE, IDLE_NONE);

        // A layer size written beyond the range of the neuron counter.
        run_phase(2047, 60, IDLE_SOME, IDLE_SOME);

        // Lowering the layer size below the counter wraps it on the next result.
        run_phase(7, 110, IDLE_ALWAYS, IDLE_ALWAYS);
        run_phase(1, 80, IDLE_SOME, IDLE_SOME);

        drain();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("dense_neuron_sigmoid_core: match");
        end else begin
            $display("dense_neuron_sigmoid_core: mismatch");
        end
        $finish;
    end

endmodule
